/* rtl/core/assert_macros.svh */
// Assertion macros for the rectangle-fill command generator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while reset is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/lcdrf_pkg.sv */
// Shared constants, types and register codes for the rectangle-fill command generator
package lcdrf_pkg;

    // Default native panel size
    localparam int PANEL_WIDTH_DEF  = 240;
    localparam int PANEL_HEIGHT_DEF = 320;

    // Field widths
    localparam int VAL_W   = 16;
    localparam int CNT_W   = 17;
    localparam int ADDR_W  = 8;
    localparam int COORD_W = 17;

    // Controller register addresses
    localparam logic [ADDR_W-1:0] REG_WIN_H_START = 8'h50;
    localparam logic [ADDR_W-1:0] REG_WIN_H_END   = 8'h51;
    localparam logic [ADDR_W-1:0] REG_WIN_V_START = 8'h52;
    localparam logic [ADDR_W-1:0] REG_WIN_V_END   = 8'h53;
    localparam logic [ADDR_W-1:0] REG_CURSOR_X    = 8'h20;
    localparam logic [ADDR_W-1:0] REG_CURSOR_Y    = 8'h21;
    localparam logic [ADDR_W-1:0] REG_GRAM        = 8'h22;

    // Request kinds
    localparam logic CMD_FILL  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Write sequence steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_WIN_X1   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_WIN_X2   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_WIN_Y1   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_WIN_Y2   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_CUR_X    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_CUR_Y    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_GRAM     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_FULL_X1  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_FULL_X2  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FULL_Y1  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_FULL_Y2  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_FULL_CX  = 4'd11;
    localparam logic [STEP_W-1:0] STEP_FULL_CY  = 4'd12;

    // One clipped, mapped request ready for the write sequencer
    typedef struct packed {
        logic             cmd;
        logic [VAL_W-1:0] a1;
        logic [VAL_W-1:0] a2;
        logic [VAL_W-1:0] b1;
        logic [VAL_W-1:0] b2;
        logic [VAL_W-1:0] cx;
        logic [VAL_W-1:0] cy;
        logic [VAL_W-1:0] color;
        logic [CNT_W-1:0] count;
    } lcdrf_item_t;

endpackage

/* rtl/core/lcdrf_emit.sv */
// Write sequencer: turns one mapped request into its register writes, one per cycle while out_ready holds
module lcdrf_emit
    import lcdrf_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        rotation,
    input  logic              item_valid,
    output logic              item_ready,
    input  lcdrf_item_t       item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] out_addr,
    output logic [VAL_W-1:0]  out_value,
    output logic [CNT_W-1:0]  out_count,
    output logic              out_last
);

`include "assert_macros.svh"

    localparam logic [VAL_W-1:0] PW_MAX = VAL_W'(PANEL_WIDTH - 1);
    localparam logic [VAL_W-1:0] PH_MAX = VAL_W'(PANEL_HEIGHT - 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    lcdrf_item_t       item_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_last_reg;

    logic              can_out;
    logic              fire;
    logic              final_step;
    logic              load;
    logic [ADDR_W-1:0] addr_sel;
    logic [VAL_W-1:0]  value_sel;
    logic [CNT_W-1:0]  count_sel;
    logic [VAL_W-1:0]  full_cx;
    logic [VAL_W-1:0]  full_cy;

    // Output register frees when empty or taken
    assign can_out    = !out_valid_reg || out_ready;
    assign fire       = busy_reg && can_out;
    assign final_step = (item_reg.cmd == CMD_PIXEL) ? (step_reg == STEP_GRAM)
                                                    : (step_reg == STEP_FULL_CY);
    assign item_ready = !busy_reg || (fire && final_step);
    assign load       = item_valid && item_ready;

    // Full-screen cursor corner for the current rotation
    assign full_cx = (rotation == 2'd1 || rotation == 2'd2) ? PW_MAX : '0;
    assign full_cy = rotation[1] ? PH_MAX : '0;

    // Select the write for the current step
    always_comb
    begin
        count_sel = CNT_W'(1);
        unique case (step_reg)
            STEP_WIN_X1:  begin addr_sel = REG_WIN_H_START; value_sel = item_reg.a1; end
            STEP_WIN_X2:  begin addr_sel = REG_WIN_H_END;   value_sel = item_reg.a2; end
            STEP_WIN_Y1:  begin addr_sel = REG_WIN_V_START; value_sel = item_reg.b1; end
            STEP_WIN_Y2:  begin addr_sel = REG_WIN_V_END;   value_sel = item_reg.b2; end
            STEP_CUR_X:   begin addr_sel = REG_CURSOR_X;    value_sel = item_reg.cx; end
            STEP_CUR_Y:   begin addr_sel = REG_CURSOR_Y;    value_sel = item_reg.cy; end
            STEP_GRAM:
            begin
                addr_sel  = REG_GRAM;
                value_sel = item_reg.color;
                count_sel = item_reg.count;
            end
            STEP_FULL_X1: begin addr_sel = REG_WIN_H_START; value_sel = '0;     end
            STEP_FULL_X2: begin addr_sel = REG_WIN_H_END;   value_sel = PW_MAX; end
            STEP_FULL_Y1: begin addr_sel = REG_WIN_V_START; value_sel = '0;     end
            STEP_FULL_Y2: begin addr_sel = REG_WIN_V_END;   value_sel = PH_MAX; end
            STEP_FULL_CX: begin addr_sel = REG_CURSOR_X;    value_sel = full_cx; end
            STEP_FULL_CY: begin addr_sel = REG_CURSOR_Y;    value_sel = full_cy; end
            default:      begin addr_sel = REG_GRAM;        value_sel = '0;     end
        endcase
    end

    // Advance the step, or load the next request
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (load)
        begin
            busy_next = 1'b1;
            step_next = (item.cmd == CMD_PIXEL) ? STEP_CUR_X : STEP_WIN_X1;
        end
        else if (fire)
        begin
            if (final_step)
                busy_next = 1'b0;
            else
                step_next = step_reg + STEP_W'(1);
        end
    end

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_WIN_X1;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item;
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (can_out)
            out_valid_reg <= fire;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_addr_reg  <= addr_sel;
            out_value_reg <= value_sel;
            out_count_reg <= count_sel;
            out_last_reg  <= final_step;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_addr  = out_addr_reg;
    assign out_value = out_value_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

    `ASSERT_CLK(a_step_range, busy_reg |-> (step_reg <= STEP_FULL_CY), "step beyond sequence end")
    `ASSERT_CLK(a_pixel_steps, (busy_reg && item_reg.cmd == CMD_PIXEL) |-> (step_reg >= STEP_CUR_X && step_reg <= STEP_GRAM), "pixel request outside cursor steps")
    `ASSERT_CLK(a_last_addr, (out_valid_reg && out_last_reg) |-> (out_addr_reg == REG_CURSOR_Y || out_addr_reg == REG_GRAM), "final write has wrong register")
    `ASSERT_CLK(a_load_idle, (item_valid && busy_reg && !fire) |=> ($stable(step_reg) && busy_reg), "sequencer moved while stalled")

endmodule

/* rtl/core/lcd_rect_fill_command_generator_top.sv */
// Top level: clip and map pipeline feeding the register write sequencer
// The first register write passes through stages 1 to 4, the sequencer step register and its output register.
// A fill makes 13 register writes and a pixel 3, issued one write per cycle while m_tready allows;
// a request that clips away takes one pipeline slot and no output write.
// The four-stage clip/map pipeline keeps taking requests while the sequencer works, until it fills.
// Reset (rst_n low, asynchronous) empties the pipeline and sets rotation to 0.
module lcd_rect_fill_command_generator_top
    import lcdrf_pkg::*;
#(
    parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,     // rotation
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,      // pos_x, pos_y, rect_width, rect_height, pixel_color
    input  logic        s_tuser,      // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // register_address, register_value, repeat_count, zero pad
    output logic        m_tlast       // last
);

    localparam logic signed [COORD_W-1:0] PW_S = COORD_W'(PANEL_WIDTH);
    localparam logic signed [COORD_W-1:0] PH_S = COORD_W'(PANEL_HEIGHT);
    localparam logic [VAL_W-1:0] PW_MAX = VAL_W'(PANEL_WIDTH - 1);
    localparam logic [VAL_W-1:0] PH_MAX = VAL_W'(PANEL_HEIGHT - 1);

    logic [1:0] rotation_reg;

    // Stage 1: corners
    logic                      s1_valid_reg;
    logic                      s1_cmd_reg;
    logic signed [COORD_W-1:0] s1_x1_reg, s1_y1_reg, s1_x2_reg, s1_y2_reg;
    logic                      s1_size_ok_reg;
    logic [VAL_W-1:0]          s1_color_reg;
    // Stage 2: clipped corners
    logic                      s2_valid_reg;
    logic                      s2_vis_reg;
    logic                      s2_cmd_reg;
    logic [VAL_W-1:0]          s2_x1_reg, s2_y1_reg, s2_x2_reg, s2_y2_reg;
    logic [VAL_W-1:0]          s2_color_reg;
    // Stage 3: native window and size
    logic                      s3_valid_reg;
    logic                      s3_vis_reg;
    lcdrf_item_t               s3_item_reg;
    logic [VAL_W-1:0]          s3_w_reg, s3_h_reg;
    // Stage 4: pixel count
    logic                      s4_valid_reg;
    lcdrf_item_t               s4_item_reg;
    lcdrf_item_t               s4_item_next;

    logic s1_ready, s2_ready, s3_ready, s4_ready;
    logic s_accept;

    logic signed [COORD_W-1:0] in_x, in_y, in_w, in_h;
    logic signed [COORD_W-1:0] lw, lh;
    logic                      vis;
    logic signed [COORD_W-1:0] cx1, cy1, cx2, cy2;
    logic [VAL_W-1:0]          a1, a2, b1, b2, ccx, ccy;
    logic [2*VAL_W-1:0]        product;

    logic              emit_ready;
    logic [ADDR_W-1:0] out_addr;
    logic [VAL_W-1:0]  out_value;
    logic [CNT_W-1:0]  out_count;

    // Hold the rotation register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rotation_reg <= 2'd0;
        else if (cfg_valid)
            rotation_reg <= cfg_data;
    end

    // Stage handshakes: a stage takes new data when empty or draining
    assign s4_ready = !s4_valid_reg || emit_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;
    assign s_accept = s_tvalid && s1_ready;

    // Stage 1: widen inputs and form right and bottom edges
    assign in_x = COORD_W'(signed'(s_tdata[15:0]));
    assign in_y = COORD_W'(signed'(s_tdata[31:16]));
    assign in_w = COORD_W'(signed'(s_tdata[47:32]));
    assign in_h = COORD_W'(signed'(s_tdata[63:48]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_cmd_reg   <= s_tuser;
            s1_x1_reg    <= in_x;
            s1_y1_reg    <= in_y;
            s1_color_reg <= s_tdata[79:64];
            if (s_tuser == CMD_PIXEL)
            begin
                s1_x2_reg      <= in_x;
                s1_y2_reg      <= in_y;
                s1_size_ok_reg <= 1'b1;
            end
            else
            begin
                s1_x2_reg      <= in_x + in_w - COORD_W'(1);
                s1_y2_reg      <= in_y + in_h - COORD_W'(1);
                s1_size_ok_reg <= (in_w > 0) && (in_h > 0);
            end
        end
    end

    // Stage 2: visibility test and clipping to the logical screen
    assign lw = rotation_reg[0] ? PH_S : PW_S;
    assign lh = rotation_reg[0] ? PW_S : PH_S;
    assign vis = s1_size_ok_reg && (s1_x1_reg < lw) && (s1_y1_reg < lh)
                 && (s1_x2_reg >= 0) && (s1_y2_reg >= 0);
    assign cx1 = (s1_x1_reg < 0) ? '0 : s1_x1_reg;
    assign cy1 = (s1_y1_reg < 0) ? '0 : s1_y1_reg;
    assign cx2 = (s1_x2_reg >= lw) ? lw - COORD_W'(1) : s1_x2_reg;
    assign cy2 = (s1_y2_reg >= lh) ? lh - COORD_W'(1) : s1_y2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_vis_reg   <= vis;
            s2_cmd_reg   <= s1_cmd_reg;
            s2_x1_reg    <= cx1[VAL_W-1:0];
            s2_y1_reg    <= cy1[VAL_W-1:0];
            s2_x2_reg    <= cx2[VAL_W-1:0];
            s2_y2_reg    <= cy2[VAL_W-1:0];
            s2_color_reg <= s1_color_reg;
        end
    end

    // Stage 3: map logical corners to native panel coordinates
    always_comb
    begin
        unique case (rotation_reg)
            2'd1:
            begin
                a1 = PW_MAX - s2_y2_reg; a2 = PW_MAX - s2_y1_reg;
                b1 = s2_x1_reg;          b2 = s2_x2_reg;
                ccx = a2; ccy = b1;
            end
            2'd2:
            begin
                a1 = PW_MAX - s2_x2_reg; a2 = PW_MAX - s2_x1_reg;
                b1 = PH_MAX - s2_y2_reg; b2 = PH_MAX - s2_y1_reg;
                ccx = a2; ccy = b2;
            end
            2'd3:
            begin
                a1 = s2_y1_reg;          a2 = s2_y2_reg;
                b1 = PH_MAX - s2_x2_reg; b2 = PH_MAX - s2_x1_reg;
                ccx = a1; ccy = b2;
            end
            default:
            begin
                a1 = s2_x1_reg; a2 = s2_x2_reg;
                b1 = s2_y1_reg; b2 = s2_y2_reg;
                ccx = a1; ccy = b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_ready)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_vis_reg        <= s2_vis_reg;
            s3_item_reg.cmd   <= s2_cmd_reg;
            s3_item_reg.a1    <= a1;
            s3_item_reg.a2    <= a2;
            s3_item_reg.b1    <= b1;
            s3_item_reg.b2    <= b2;
            s3_item_reg.cx    <= ccx;
            s3_item_reg.cy    <= ccy;
            s3_item_reg.color <= s2_color_reg;
            s3_item_reg.count <= '0;
            s3_w_reg          <= s2_x2_reg - s2_x1_reg + VAL_W'(1);
            s3_h_reg          <= s2_y2_reg - s2_y1_reg + VAL_W'(1);
        end
    end

    // Stage 4: pixel count; drop requests that clip away
    assign product = s3_w_reg * s3_h_reg;

    always_comb
    begin
        s4_item_next       = s3_item_reg;
        s4_item_next.count = product[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (s4_ready)
            s4_valid_reg <= s3_valid_reg && s3_vis_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && s3_valid_reg)
            s4_item_reg <= s4_item_next;
    end

    // Register write sequencer
    lcdrf_emit #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .rotation   (rotation_reg),
        .item_valid (s4_valid_reg),
        .item_ready (emit_ready),
        .item       (s4_item_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_addr   (out_addr),
        .out_value  (out_value),
        .out_count  (out_count),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'd0, out_count, out_value, out_addr};

endmodule
